[hw/rtl/ffc_pkg.sv]
// ----------------------------------------------------------------------------
// ffc_pkg
// Shared types and constants for the float format converter.
// ----------------------------------------------------------------------------
package ffc_pkg;

   localparam int unsigned OperandWidth = 32;

   typedef enum logic [1:0] {
      MODE_F32_TO_BF16 = 2'd0,
      MODE_BF16_TO_F32 = 2'd1,
      MODE_F32_TO_F16  = 2'd2,
      MODE_F16_TO_F32  = 2'd3
   } mode_type;

   localparam logic [15:0] HALF_INF       = 16'h7c00;
   localparam logic [31:0] EXP32_INF      = 32'h7f80_0000;
   localparam logic [7:0]  F16_EXP_OFFSET = 8'd112;

endpackage

[hw/rtl/ffc_convert.sv]
// ----------------------------------------------------------------------------
// ffc_convert
// Combinational conversion datapath for all four modes.
// ----------------------------------------------------------------------------
module ffc_convert (
   input  ffc_pkg::mode_type mode,
   input  logic [31:0]       operand_bits,
   output logic [31:0]       result_bits
);
   import ffc_pkg::*;

   logic [31:0] bf_sum;
   logic [31:0] r_bf16;
   logic [31:0] r_wide_bf;
   logic [15:0] h16;
   logic [31:0] r_wide_h;

   // fp32 to bf16 with add-and-truncate round-to-nearest-even; bf16 to fp32 by zero-filling the low half
   always_comb begin
      bf_sum = operand_bits + 32'h0000_7fff + {31'd0, operand_bits[16]};
      r_bf16 = {16'd0, bf_sum[31:16]};
      r_wide_bf = {operand_bits[15:0], 16'd0};
   end

   // fp32 to fp16
   always_comb begin
      logic        sgn;
      logic [7:0]  ex;
      logic [22:0] man;
      logic [23:0] sig;
      logic [4:0]  sh;
      logic [23:0] q;
      logic [23:0] rem_mask;
      logic [23:0] rem;
      logic [23:0] half;
      logic [10:0] hm;
      logic [5:0]  hex;
      sgn = operand_bits[31];
      ex  = operand_bits[30:23];
      man = operand_bits[22:0];
      sig = {1'b1, man};
      sh  = 5'd0;
      q = '0; rem_mask = '0; rem = '0; half = '0; hm = '0; hex = '0;
      h16 = {sgn, 15'd0};
      if (ex == 8'hff) begin
         if (man == '0) h16 = {sgn, 15'd0} | HALF_INF;
         else h16 = {sgn, 15'd0} | HALF_INF | {6'd0, man[22:13]} | 16'd1;
      end else if (ex > 8'd142) begin
         h16 = {sgn, 15'd0} | HALF_INF;
      end else if (ex < 8'd103) begin
         h16 = {sgn, 15'd0};
      end else if (ex < 8'd113) begin
         // subnormal: shift by -unb-1 = 126-ex, range 14..23
         sh = 5'(8'd126 - ex);
         q = sig >> sh;
         rem_mask = (24'd1 << sh) - 24'd1;
         rem = sig & rem_mask;
         half = 24'd1 << (sh - 5'd1);
         if (rem > half || (rem == half && q[0])) q = q + 24'd1;
         h16 = {sgn, 15'd0} | q[15:0];
      end else begin
         hex = 6'(ex - 8'd112);
         hm  = {1'b0, man[22:13]};
         if (man[12:0] > 13'h1000 || (man[12:0] == 13'h1000 && hm[0])) begin
            hm = hm + 11'd1;
            if (hm[10]) begin
               hm = '0;
               hex = hex + 6'd1;
            end
         end
         if (hex >= 6'h1f) h16 = {sgn, 15'd0} | HALF_INF;
         else h16 = {sgn, hex[4:0], hm[9:0]};
      end
   end

   // fp16 to fp32, subnormals normalized by a leading-zero count
   always_comb begin
      logic       sgn;
      logic [4:0] ex;
      logic [9:0] man;
      logic [3:0] lz;
      logic [10:0] nm;
      logic [7:0] e32;
      sgn = operand_bits[15];
      ex  = operand_bits[14:10];
      man = operand_bits[9:0];
      lz  = 4'd0;
      for (int i = 0; i < 10; i++) begin
         if (man[i]) lz = 4'(9 - i);
      end
      nm  = {1'b0, man} << (lz + 4'd1);
      e32 = 8'd112 - {4'd0, lz};
      if (ex == 5'd0) begin
         if (man == '0) r_wide_h = {sgn, 31'd0};
         else r_wide_h = {sgn, e32, nm[9:0], 13'd0};
      end else if (ex == 5'h1f) begin
         r_wide_h = {sgn, 31'd0} | EXP32_INF | {9'd0, man, 13'd0};
      end else begin
         r_wide_h = {sgn, {3'd0, ex} + F16_EXP_OFFSET, man, 13'd0};
      end
   end

   // mode select
   always_comb begin
      case (mode)
         MODE_F32_TO_BF16: result_bits = r_bf16;
         MODE_BF16_TO_F32: result_bits = r_wide_bf;
         MODE_F32_TO_F16:  result_bits = {16'd0, h16};
         default:          result_bits = r_wide_h;
      endcase
   end

endmodule

[hw/rtl/float_format_converter_core.sv]
// ----------------------------------------------------------------------------
// float_format_converter_core
// Converts between fp32, bf16 and fp16 bit patterns, one beat per cycle unless rsp_ready stalls.
// ----------------------------------------------------------------------------
// path: a request passes through the input register, then the result register, before
// its response beat is offered on rsp_valid
// throughput: one beat per cycle unless rsp_ready stalls, set by the single-pass conversion logic
// each register stage advances when its downstream slot is empty or drains
// reset clears both stage valid flags; payload registers are not reset
module float_format_converter_core (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [1:0]          req_mode,
   input  logic [31:0]         req_operand_bits,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [31:0]         rsp_result_bits
);
   import ffc_pkg::*;

   logic        in_vld_ff;
   logic        in_vld_in;
   mode_type    in_mode_ff;
   logic [31:0] in_op_ff;
   logic        out_vld_ff;
   logic        out_vld_in;
   logic [31:0] out_res_ff;
   logic [31:0] conv_res;
   logic        out_load;
   logic        in_load;

   // stage handshakes
   assign out_load  = in_vld_ff && (!out_vld_ff || rsp_ready);
   assign req_ready = !in_vld_ff || out_load;
   assign in_load   = req_valid && req_ready;
   assign in_vld_in  = in_load || (in_vld_ff && !out_load);
   assign out_vld_in = out_load || (out_vld_ff && !rsp_ready);

   // input register
   always_ff @(posedge clock) begin
      if (reset) in_vld_ff <= 1'b0;
      else in_vld_ff <= in_vld_in;
      if (in_load) begin
         in_mode_ff <= mode_type'(req_mode);
         in_op_ff   <= req_operand_bits;
      end
   end

   ffc_convert u_convert (
      .mode         (in_mode_ff),
      .operand_bits (in_op_ff),
      .result_bits  (conv_res)
   );

   // result register
   always_ff @(posedge clock) begin
      if (reset) out_vld_ff <= 1'b0;
      else out_vld_ff <= out_vld_in;
      if (out_load) out_res_ff <= conv_res;
   end

   assign rsp_valid       = out_vld_ff;
   assign rsp_result_bits = out_res_ff;

`ifndef NO_ASSERTIONS
   // a stalled result beat is held
   a_hold: assert property (@(posedge clock) disable iff (reset)
      out_vld_ff && !rsp_ready |=> out_vld_ff && $stable(out_res_ff))
      else $error("result beat changed while stalled");
   // an accepted request reaches the input stage
   a_take: assert property (@(posedge clock) disable iff (reset)
      in_load |=> in_vld_ff)
      else $error("accepted beat lost");
   // 16-bit results keep the upper half clear
   a_upper: assert property (@(posedge clock) disable iff (reset)
      out_load && (in_mode_ff == MODE_F32_TO_BF16 || in_mode_ff == MODE_F32_TO_F16)
      |=> out_res_ff[31:16] == 16'd0)
      else $error("upper half not zero");
`endif

endmodule
